// File: hdl/tnb_pkg.sv
package tnb_pkg;

  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  localparam int unsigned DIV_W   = 64;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ITER_W  = 5;
  localparam int unsigned ANGLE_W = 34;

  localparam logic [1:0] CFG_MIN_FREQ = 2'd0;
  localparam logic [1:0] CFG_MAX_FREQ = 2'd1;
  localparam logic [1:0] CFG_RATE     = 2'd2;
  localparam logic [1:0] CFG_QUALITY  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RETUNE = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [15:0] sample_in;
    logic [15:0]       new_freq;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic              clipped;
    logic              passing_through;
  } out_t;

  // arctangent of 2^-i in q30
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [ANGLE_W-1:0] r;
    begin
      case (i)
        5'd0:    r = 34'sd843314857;
        5'd1:    r = 34'sd497837829;
        5'd2:    r = 34'sd263043837;
        5'd3:    r = 34'sd133525159;
        5'd4:    r = 34'sd67021687;
        5'd5:    r = 34'sd33543516;
        5'd6:    r = 34'sd16775851;
        5'd7:    r = 34'sd8388437;
        5'd8:    r = 34'sd4194283;
        5'd9:    r = 34'sd2097149;
        5'd10:   r = 34'sd1048576;
        default: r = $signed(34'(64'd1 << (5'd30 - i)));
      endcase
      atan_q30 = r;
    end
  endfunction

endpackage

// File: hdl/tnb_div.sv
module tnb_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tnb_pkg::DIV_W-1:0]   num_i,
  input  logic [tnb_pkg::DIV_W-1:0]   den_i,
  output logic                        done_o,
  output logic [tnb_pkg::DIV_W-1:0]   quo_o
);

  logic [tnb_pkg::DIV_W:0]   rem_q;
  logic [tnb_pkg::DIV_W-1:0] quo_q;
  logic [tnb_pkg::DIV_W-1:0] den_q;
  logic [tnb_pkg::CNT_W-1:0] cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [tnb_pkg::DIV_W:0]   rem_sh;
  logic                      fits;

  // one quotient bit a cycle, restoring
  assign rem_sh = {rem_q[tnb_pkg::DIV_W-1:0], quo_q[tnb_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= num_i;
        den_q  <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q <= {quo_q[tnb_pkg::DIV_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {tnb_pkg::CNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/tnb_cordic.sv
module tnb_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        ang_i,
  output logic               done_o,
  output logic [30:0]        sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [tnb_pkg::ITER_W-1:0] LAST = tnb_pkg::ITER_W'(CORDIC_STEPS - 1);
  localparam logic signed [tnb_pkg::ANGLE_W-1:0] ONE = $signed(34'(tnb_pkg::ONE_Q30));

  logic signed [tnb_pkg::ANGLE_W-1:0] x_q, y_q, z_q;
  logic [tnb_pkg::ITER_W-1:0]         i_q;
  logic                               flip_q, busy_q, done_q;

  logic signed [tnb_pkg::ANGLE_W-1:0] dx, dy, at, xc;
  logic                               fold;

  assign dx   = y_q >>> i_q;
  assign dy   = x_q >>> i_q;
  assign at   = tnb_pkg::atan_q30(i_q);
  assign fold = ang_i > tnb_pkg::HALF_PI_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // fold into the first quadrant, cosine flips sign
        x_q    <= $signed(34'(tnb_pkg::GAIN_Q30));
        y_q    <= '0;
        z_q    <= fold ? $signed(34'(tnb_pkg::PI_Q30)) - $signed({2'b0, ang_i})
                       : $signed({2'b0, ang_i});
        flip_q <= fold;
        i_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (z_q >= 0) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
        if (i_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (y_q < 0)        sin_o = '0;
    else if (y_q > ONE) sin_o = 31'(tnb_pkg::ONE_Q30);
    else                sin_o = y_q[30:0];
    if (x_q > ONE)       xc = ONE;
    else if (x_q < -ONE) xc = -ONE;
    else                 xc = x_q;
    cos_o = flip_q ? 32'(-xc) : 32'(xc);
  end

  assign done_o = done_q;

endmodule

// File: hdl/tracking_notch_biquad.sv
// channel  direction  handshake                 word
// cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_stall_o   in_word_i  (tnb_pkg::in_t)
// out      out        out_valid_o / out_stall_i out_word_o (tnb_pkg::out_t)
//
// a sample word takes three products on the one multiplier, then round
// a retune word runs the shared 64-step divider (angle, alpha, 1/a0)
// and the cordic iterations, which come between the angle and alpha divisions
// a retune to the same frequency or out of band finishes without leaving idle
// reset gives bypass coefficients and cleared history
// the output register holds a word under stall; the next input is taken meanwhile
module tracking_notch_biquad #(
  parameter int CORDIC_STEPS   = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tnb_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tnb_pkg::out_t out_word_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC0, ST_MAC1, ST_MAC2, ST_MAC3, ST_FIN,
    ST_WMUL, ST_WGO, ST_WWAIT, ST_CWAIT, ST_AWAIT, ST_A0GO, ST_A0WAIT,
    ST_BMUL, ST_BFIN
  } state_e;

  localparam logic signed [31:0] COEF_ONE   = $signed(32'(64'd1 << COEF_FRAC_BITS));
  localparam logic [63:0]        A0_BASE    = 64'd1 << (COEF_FRAC_BITS + 30);
  localparam logic signed [51:0] ROUND_HALF = $signed(52'(64'd1 << (COEF_FRAC_BITS - 1)));

  state_e state_q;
  logic [15:0] min_q, max_q, rate_q, qual_q;
  logic signed [15:0] h1_q, h2_q, y1_q, y2_q, x_q;
  logic signed [31:0] gain_q, cross_q, fb_q;
  logic bypass_q;
  logic [15:0] cur_q, freq_q;
  logic signed [65:0] prod_q;
  logic signed [51:0] acc_q;
  logic [41:0] alpha_q;
  logic [30:0] a0_q;
  logic out_valid_q;
  tnb_pkg::out_t out_q;

  logic signed [32:0] mul_a, mul_b;
  logic div_start, div_done, cord_start, cord_done;
  logic [63:0] div_num, div_den, div_quo, a0_den;
  logic [30:0] sin_w;
  logic signed [31:0] cos_w;
  logic [31:0] cos_abs;
  logic [18:0] f5, cur6, cur4;
  logic oob, accept, out_free;
  logic signed [51:0] y_wide;
  logic signed [15:0] y_sat;
  logic clip;
  logic [35:0] mag;
  logic signed [36:0] b1;

  tnb_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  tnb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i(cord_start), .ang_i(div_quo[31:0]),
    .done_o(cord_done), .sin_o(sin_w), .cos_o(cos_w)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign f5   = {1'b0, in_word_i.new_freq, 2'b0} + {3'b0, in_word_i.new_freq};
  assign cur6 = {1'b0, cur_q, 2'b0} + {2'b0, cur_q, 1'b0};
  assign cur4 = {1'b0, cur_q, 2'b0};
  assign oob  = in_word_i.new_freq < min_q || in_word_i.new_freq > max_q ||
                rate_q == 16'd0 || {3'b0, in_word_i.new_freq} > {rate_q, 3'b0};
  assign cos_abs = cos_w < 0 ? 32'(-cos_w) : 32'(cos_w);
  assign a0_den  = 64'(tnb_pkg::ONE_Q30) + {22'b0, alpha_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MAC0: begin
        mul_a = 33'(gain_q);
        mul_b = 33'(17'(x_q) + 17'(h2_q));
      end
      ST_MAC1: begin
        mul_a = 33'(cross_q);
        mul_b = 33'(17'(h1_q) - 17'(y1_q));
      end
      ST_MAC2: begin
        mul_a = 33'(fb_q);
        mul_b = 33'(y2_q);
      end
      ST_WMUL: begin
        mul_a = $signed({1'b0, tnb_pkg::PI_Q30});
        mul_b = $signed({17'b0, freq_q});
      end
      ST_BMUL: begin
        mul_a = $signed({2'b0, cos_abs[30:0]});
        mul_b = $signed({2'b0, a0_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    cord_start = 1'b0;
    case (state_q)
      ST_WGO: begin
        div_start = 1'b1;
        div_num   = prod_q[63:0];
        div_den   = {45'b0, rate_q, 3'b0};
      end
      ST_WWAIT: cord_start = div_done;
      ST_CWAIT: begin
        div_start = cord_done;
        div_num   = {22'b0, sin_w, 11'b0};
        div_den   = {48'b0, (qual_q == 16'd0) ? 16'd1 : qual_q};
      end
      ST_A0GO: begin
        div_start = 1'b1;
        div_num   = A0_BASE + (a0_den >> 1);
        div_den   = a0_den;
      end
      default: ;
    endcase
  end

  always_comb begin
    y_wide = (acc_q + ROUND_HALF) >>> COEF_FRAC_BITS;
    clip   = 1'b1;
    if (y_wide > 52'sd32767)       y_sat = 16'sh7fff;
    else if (y_wide < -52'sd32768) y_sat = -16'sh8000;
    else begin
      y_sat = y_wide[15:0];
      clip  = 1'b0;
    end
    mag = 36'((prod_q[61:0] + (62'd1 << 28)) >> 29);
    b1  = (cos_w >= 0) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= 16'd1280;
      max_q       <= 16'd8000;
      rate_q      <= 16'd1000;
      qual_q      <= 16'd12288;
      h1_q        <= '0;
      h2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      gain_q      <= COEF_ONE;
      cross_q     <= '0;
      fb_q        <= '0;
      bypass_q    <= 1'b1;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i && !(state_q == ST_FIN)) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tnb_pkg::CFG_MIN_FREQ: min_q  <= cfg_data_i;
          tnb_pkg::CFG_MAX_FREQ: max_q  <= cfg_data_i;
          tnb_pkg::CFG_RATE:     rate_q <= cfg_data_i;
          tnb_pkg::CFG_QUALITY:  qual_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_word_i.op == tnb_pkg::OP_SAMPLE) begin
              x_q     <= in_word_i.sample_in;
              state_q <= ST_MAC0;
            end else if (in_word_i.new_freq != cur_q) begin
              // big jump clears the delay line
              if (cur_q > min_q && (f5 > cur6 || f5 < cur4)) begin
                h1_q <= '0;
                h2_q <= '0;
                y1_q <= '0;
                y2_q <= '0;
              end
              cur_q <= in_word_i.new_freq;
              if (oob) begin
                gain_q   <= COEF_ONE;
                cross_q  <= '0;
                fb_q     <= '0;
                bypass_q <= 1'b1;
              end else begin
                freq_q  <= in_word_i.new_freq;
                state_q <= ST_WMUL;
              end
            end
          end
        end
        ST_MAC0: state_q <= ST_MAC1;
        ST_MAC1: begin
          acc_q   <= prod_q[51:0];
          state_q <= ST_MAC2;
        end
        ST_MAC2: begin
          acc_q   <= acc_q + prod_q[51:0];
          state_q <= ST_MAC3;
        end
        ST_MAC3: begin
          acc_q   <= acc_q - prod_q[51:0];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // a held word stays put until the receiver takes it
          if (out_free) begin
            out_q.sample_out      <= y_sat;
            out_q.clipped         <= clip;
            out_q.passing_through <= bypass_q;
            out_valid_q           <= 1'b1;
            h2_q    <= h1_q;
            h1_q    <= x_q;
            y2_q    <= y1_q;
            y1_q    <= y_sat;
            state_q <= ST_IDLE;
          end
        end
        ST_WMUL:  state_q <= ST_WGO;
        ST_WGO:   state_q <= ST_WWAIT;
        ST_WWAIT: if (div_done) state_q <= ST_CWAIT;
        ST_CWAIT: if (cord_done) state_q <= ST_AWAIT;
        ST_AWAIT: begin
          if (div_done) begin
            alpha_q <= div_quo[41:0];
            state_q <= ST_A0GO;
          end
        end
        ST_A0GO: state_q <= ST_A0WAIT;
        ST_A0WAIT: begin
          if (div_done) begin
            a0_q    <= div_quo[30:0];
            state_q <= ST_BMUL;
          end
        end
        ST_BMUL: state_q <= ST_BFIN;
        ST_BFIN: begin
          gain_q <= $signed({1'b0, a0_q});
          if (b1 > 37'sd2147483647)       cross_q <= 32'sh7fffffff;
          else if (b1 < -37'sd2147483648) cross_q <= 32'sh80000000;
          else                            cross_q <= b1[31:0];
          fb_q     <= $signed({a0_q, 1'b0}) - COEF_ONE;
          bypass_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_bypass_coefs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bypass_q |-> (gain_q == COEF_ONE && cross_q == 32'sd0 && fb_q == 32'sd0))
    else $error("bypass with tuned coefficients");

  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == ST_CWAIT)
    else $error("cordic finished outside its wait");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.clipped) |->
      (out_word_o.sample_out == 16'sh7fff || out_word_o.sample_out == -16'sh8000))
    else $error("clipped word not at a rail");

endmodule
